// ===== src/lru_key_value_cache_assert.svh =====
// Assertion macros shared by the cache checker
`ifndef LRU_KEY_VALUE_CACHE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_ASSERT_SVH

// clocked check, quiet while reset is held
`define LKVC_ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// clocked check that also spans reset
`define LKVC_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== src/lkvc_pkg.sv =====
// Shared constants and types for the LRU key-value cache
package lkvc_pkg;

    localparam int unsigned ENTRIES = 16;
    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VAL_W   = 32;
    localparam int unsigned CAP_W   = $clog2(ENTRIES + 1);

    localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(ENTRIES);
    localparam logic [CAP_W-1:0] CAP_MIN   = CAP_W'(1);
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(ENTRIES);

    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_WRITE  = 1'b1;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_entry;

    typedef struct packed {
        logic             hit;
        logic [VAL_W-1:0] value;
    } t_hit;

    typedef struct packed {
        logic clear;
        logic step;
        logic insert;
    } t_cell_ctl;

endpackage

// ===== src/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache
//
// Input channel: i_valid / o_stall carry one transaction of i_mode, i_key and
// i_write_value. A lookup (mode 0) yields one output transaction on o_valid /
// i_stall with o_hit and o_read_value (zero on a miss); a write yields none.
// Entries sit in a row of cells ordered by recency, cell 0 most recent. Every
// cell compares its key in parallel; a hit or an insertion shifts the cells
// in front of the match (or all cells) back by one and loads the new head.
// An insertion at full capacity pushes the least recent entry out of range.
// A lookup's acceptance loads the output register; one transaction is taken
// per cycle while o_stall is low, bounded by the key compare and match chain
// across the row. The output register holds its result while i_stall is high,
// and o_stall rises only while a result is held and stalled.
// i_cfg_we writes the capacity register (applied clamped to 1..16) and empties the
// store. Reset empties the store, sets capacity 16 and drops any result.
module lru_key_value_cache (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lkvc_pkg::CAP_W-1:0]        i_cfg_data,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic                              i_mode,
    input  logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input  logic signed [lkvc_pkg::VAL_W-1:0] i_write_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic                              o_hit,
    output logic signed [lkvc_pkg::VAL_W-1:0] o_read_value
);

    logic [lkvc_pkg::CAP_W-1:0] r_cap;
    logic [lkvc_pkg::CAP_W-1:0] w_eff_cap;
    logic                       r_out_valid;
    logic                       r_hit;
    logic [lkvc_pkg::VAL_W-1:0] r_read_value;
    logic                       w_accept;
    logic [lkvc_pkg::ENTRIES-1:0] w_in_range;
    lkvc_pkg::t_cell_ctl        w_ctl;
    lkvc_pkg::t_entry           w_head;
    lkvc_pkg::t_entry           w_entry [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_entry           w_prev  [lkvc_pkg::ENTRIES];
    lkvc_pkg::t_hit             w_chain [lkvc_pkg::ENTRIES+1];

    assign o_stall  = r_out_valid & i_stall;
    assign w_accept = i_valid & ~o_stall;

    always_comb begin
        if (r_cap == '0) begin
            w_eff_cap = lkvc_pkg::CAP_MIN;
        end else if (r_cap > lkvc_pkg::CAP_MAX) begin
            w_eff_cap = lkvc_pkg::CAP_MAX;
        end else begin
            w_eff_cap = r_cap;
        end
    end

    always_comb begin
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            w_in_range[i] = (i < int'(w_eff_cap));
        end
    end

    assign w_ctl.clear  = i_cfg_we;
    assign w_ctl.step   = w_accept;
    assign w_ctl.insert = (i_mode == lkvc_pkg::MODE_WRITE) & ~w_chain[0].hit;

    assign w_head.valid = 1'b1;
    assign w_head.key   = i_key;
    assign w_head.value = (i_mode == lkvc_pkg::MODE_WRITE) ? i_write_value
                                                           : w_chain[0].value;

    assign w_chain[lkvc_pkg::ENTRIES] = '0;

    always_comb begin
        w_prev[0] = w_head;
        for (int i = 1; i < lkvc_pkg::ENTRIES; i++) begin
            w_prev[i] = w_entry[i-1];
        end
    end

    for (genvar g = 0; g < lkvc_pkg::ENTRIES; g++) begin : g_cell
        lkvc_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_in_range (w_in_range[g]),
            .i_req_key  (i_key),
            .i_prev     (w_prev[g]),
            .i_chain    (w_chain[g+1]),
            .o_chain    (w_chain[g]),
            .o_entry    (w_entry[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= lkvc_pkg::CAP_RESET;
        end else if (i_cfg_we) begin
            r_cap <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept && (i_mode == lkvc_pkg::MODE_LOOKUP)) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (i_mode == lkvc_pkg::MODE_LOOKUP)) begin
            r_hit        <= w_chain[0].hit;
            r_read_value <= w_chain[0].hit ? w_chain[0].value : '0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hit        = r_hit;
    assign o_read_value = r_read_value;

endmodule

// ===== src/lkvc_cell.sv =====
// One recency slot of the cache: holds an entry, matches a key, shifts from its neighbour
module lkvc_cell (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lkvc_pkg::t_cell_ctl        i_ctl,
    input  logic                       i_in_range,
    input  logic [lkvc_pkg::KEY_W-1:0] i_req_key,
    input  lkvc_pkg::t_entry           i_prev,
    input  lkvc_pkg::t_hit             i_chain,
    output lkvc_pkg::t_hit             o_chain,
    output lkvc_pkg::t_entry           o_entry
);

    logic                       r_valid;
    logic [lkvc_pkg::KEY_W-1:0] r_key;
    logic [lkvc_pkg::VAL_W-1:0] r_value;
    logic                       w_match;
    logic                       w_shift;

    assign w_match       = r_valid && (r_key == i_req_key);
    assign o_chain.hit   = i_chain.hit | w_match;
    assign o_chain.value = w_match ? r_value : i_chain.value;
    assign w_shift       = i_ctl.step && (i_ctl.insert || o_chain.hit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.clear) begin
            r_valid <= 1'b0;
        end else if (w_shift) begin
            r_valid <= i_prev.valid & i_in_range;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_key   <= i_prev.key;
            r_value <= i_prev.value;
        end
    end

    assign o_entry.valid = r_valid;
    assign o_entry.key   = r_key;
    assign o_entry.value = r_value;

endmodule

// ===== src/lkvc_checker.sv =====
// Port-level checks for the LRU key-value cache, bound to the top level
`include "lru_key_value_cache_assert.svh"

module lkvc_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_cfg_we,
    input logic                              i_valid,
    input logic                              o_stall,
    input logic                              i_mode,
    input logic signed [lkvc_pkg::KEY_W-1:0] i_key,
    input logic signed [lkvc_pkg::VAL_W-1:0] i_write_value,
    input logic                              o_valid,
    input logic                              i_stall,
    input logic                              o_hit,
    input logic signed [lkvc_pkg::VAL_W-1:0] o_read_value
);

    `LKVC_ASSERT_RST(a_reset_drops_output, !i_rst_n |=> !o_valid, "output valid after reset")

    `LKVC_ASSERT_CLK(a_stalled_result_holds,
        o_valid && i_stall |=> o_valid && $stable(o_hit) && $stable(o_read_value),
        "stalled result changed")

    `LKVC_ASSERT_CLK(a_miss_reads_zero, o_valid && !o_hit |-> o_read_value == '0,
        "miss with non-zero value")

    `LKVC_ASSERT_CLK(a_lookup_gives_result,
        i_valid && !o_stall && (i_mode == lkvc_pkg::MODE_LOOKUP) |=> o_valid,
        "lookup gave no result")

    `LKVC_ASSERT_CLK(a_write_then_read_hits,
        (i_valid && !o_stall && (i_mode == lkvc_pkg::MODE_WRITE) && !i_cfg_we) ##1
        (i_valid && !o_stall && (i_mode == lkvc_pkg::MODE_LOOKUP) && (i_key == $past(i_key)))
        |=> o_hit && (o_read_value == $past(i_write_value, 2)),
        "fresh write missed on lookup")

endmodule

bind lru_key_value_cache lkvc_checker u_checker (.*);

// ===== test/lru_key_value_cache_tb.sv =====
// Self-checking testbench for the LRU key-value cache with its own store predictor
`timescale 1ns / 100ps

module lru_key_value_cache_tb;

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_cfg_we = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0]        i_cfg_data = '0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic                              i_mode = lkvc_pkg::MODE_LOOKUP;
    logic signed [lkvc_pkg::KEY_W-1:0] i_key = '0;
    logic signed [lkvc_pkg::VAL_W-1:0] i_write_value = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic                              o_hit;
    logic signed [lkvc_pkg::VAL_W-1:0] o_read_value;

    lru_key_value_cache DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_mode        (i_mode),
        .i_key         (i_key),
        .i_write_value (i_write_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_hit         (o_hit),
        .o_read_value  (o_read_value)
    );

    localparam int unsigned SETTLE_CYCLES = 4;

    logic [lkvc_pkg::KEY_W-1:0]  store_key [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0]  store_val [lkvc_pkg::ENTRIES];
    bit                          store_used [lkvc_pkg::ENTRIES];
    int unsigned                 store_age [lkvc_pkg::ENTRIES];
    int unsigned                 store_fill;
    logic [lkvc_pkg::CAP_W-1:0]  capacity_reg;

    lkvc_pkg::t_hit              expected_reads [$];
    lkvc_pkg::t_hit              want;
    logic [lkvc_pkg::KEY_W-1:0]  key_pool [$];

    int unsigned       error_count = 0;
    int unsigned       send_idle_pct = 37;
    int unsigned       recv_idle_pct = 37;
    int unsigned       hold_off_left = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void wipe_store();
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++) begin
            store_used[i] = 1'b0;
            store_age[i]  = 0;
        end
        store_fill = 0;
    endfunction

    function automatic int unsigned capacity_limit();
        int unsigned c;
        c = 32'(capacity_reg);
        if (c == 0) c = 1;
        if (c > lkvc_pkg::ENTRIES) c = lkvc_pkg::ENTRIES;
        return c;
    endfunction

    function automatic int locate_key(logic [lkvc_pkg::KEY_W-1:0] k);
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (store_used[i] && store_key[i] == k) return i;
        return -1;
    endfunction

    function automatic void promote_entry(int idx);
        int unsigned r;
        r = store_age[idx];
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (store_used[i] && store_age[i] < r) store_age[i]++;
        store_age[idx] = 0;
    endfunction

    function automatic void drop_least_recent();
        int victim;
        victim = -1;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (store_used[i] && (victim < 0 || store_age[i] > store_age[victim]))
                victim = i;
        if (victim >= 0) begin
            store_used[victim] = 1'b0;
            store_age[victim]  = 0;
            if (store_fill > 0) store_fill--;
        end
    endfunction

    function automatic void install_entry(logic [lkvc_pkg::KEY_W-1:0] k,
                                          logic [lkvc_pkg::VAL_W-1:0] v);
        int slot;
        slot = -1;
        while (store_fill >= capacity_limit() && store_fill > 0) drop_least_recent();
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (!store_used[i] && slot < 0) slot = i;
        if (slot < 0) return;
        for (int i = 0; i < lkvc_pkg::ENTRIES; i++)
            if (store_used[i]) store_age[i]++;
        store_key[slot]  = k;
        store_val[slot]  = v;
        store_used[slot] = 1'b1;
        store_age[slot]  = 0;
        store_fill++;
    endfunction

    function automatic void predict_access(logic m, logic [lkvc_pkg::KEY_W-1:0] k,
                                           logic [lkvc_pkg::VAL_W-1:0] v);
        int idx;
        lkvc_pkg::t_hit res;
        idx = locate_key(k);
        if (m == lkvc_pkg::MODE_LOOKUP) begin
            if (idx >= 0) begin
                promote_entry(idx);
                res.hit   = 1'b1;
                res.value = store_val[idx];
            end else begin
                res.hit   = 1'b0;
                res.value = '0;
            end
            expected_reads.push_back(res);
        end else if (idx >= 0) begin
            store_val[idx] = v;
            promote_entry(idx);
        end else begin
            install_entry(k, v);
        end
    endfunction

    task automatic report_mismatch(string what, logic [lkvc_pkg::VAL_W-1:0] got,
                                   logic [lkvc_pkg::VAL_W-1:0] exp_v);
        $display("%0t: %s: got %h, want %h", $realtime, what, got, exp_v);
        error_count++;
    endtask

    // enter and leave on a falling edge; valid stays high for a back-to-back caller
    task automatic send_request(logic m, logic [lkvc_pkg::KEY_W-1:0] k,
                                logic [lkvc_pkg::VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= m;
        i_key         <= k;
        i_write_value <= v;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_access(m, k, v);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (expected_reads.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic apply_capacity(logic [lkvc_pkg::CAP_W-1:0] c);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= c;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        capacity_reg = c;
        wipe_store();
    endtask

    task automatic fill_key_pool(int unsigned count);
        key_pool.delete();
        for (int i = 0; i < count; i++) key_pool.push_back($urandom());
    endtask

    task automatic test_directed_access();
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_WRITE,  32'h8000_0000, 32'h7FFF_FFFF);
        send_request(lkvc_pkg::MODE_WRITE,  32'h7FFF_FFFF, 32'h8000_0000);
        send_request(lkvc_pkg::MODE_WRITE,  32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h8000_0000, 32'hFFFF_FFFF);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(lkvc_pkg::MODE_WRITE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    endtask

    task automatic test_capacity_edges();
        apply_capacity(5'd0);
        send_request(lkvc_pkg::MODE_WRITE,  32'h0000_0001, 32'hAAAA_5555);
        send_request(lkvc_pkg::MODE_WRITE,  32'h8000_0001, 32'h5555_AAAA);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h0000_0001, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h8000_0001, 32'h0000_0000);
        apply_capacity(5'd2);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h8000_0001, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_WRITE,  32'h0000_00A0, 32'h0000_0011);
        send_request(lkvc_pkg::MODE_WRITE,  32'h0000_00B0, 32'h0000_0022);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h0000_00A0, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_WRITE,  32'h0000_00C0, 32'h0000_0033);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h0000_00B0, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h0000_00C0, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h0000_00A0, 32'h0000_0000);
        apply_capacity(5'd31);
        for (int i = 0; i < 18; i++)
            send_request(lkvc_pkg::MODE_WRITE, 32'h4000_0000 + i, i);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h4000_0000, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h4000_0002, 32'h0000_0000);
        send_request(lkvc_pkg::MODE_LOOKUP, 32'h4000_0011, 32'h0000_0000);
    endtask

    task automatic test_backpressure();
        apply_capacity(5'd8);
        fill_key_pool(10);
        @(posedge i_clk);
        hold_off_left = 300;
        @(negedge i_clk);
        send_idle_pct = 0;
        for (int i = 0; i < 60; i++)
            send_request(1'($urandom_range(1)),
                         key_pool[$urandom_range(key_pool.size() - 1)], $urandom());
        send_idle_pct = 37;
    endtask

    task automatic test_random_traffic();
        logic [lkvc_pkg::CAP_W-1:0] caps [7];
        logic [lkvc_pkg::KEY_W-1:0] k;
        caps = '{5'd16, 5'd1, 5'd3, 5'd8, 5'd17, 5'd0, 5'd0};
        caps[6] = lkvc_pkg::CAP_W'($urandom_range(31));
        for (int p = 0; p < 7; p++) begin
            apply_capacity(caps[p]);
            if (p == 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else begin
                send_idle_pct = 37;
                recv_idle_pct = 37;
            end
            fill_key_pool(capacity_limit() + 3);
            for (int i = 0; i < 175; i++) begin
                if ($urandom_range(99) < 85)
                    k = key_pool[$urandom_range(key_pool.size() - 1)];
                else
                    k = $urandom();
                send_request(1'($urandom_range(1)), k, $urandom());
            end
        end
        send_idle_pct = 37;
        recv_idle_pct = 37;
    endtask

    always @(negedge i_clk) begin
        if (hold_off_left > 0) begin
            i_stall <= 1'b1;
            hold_off_left--;
        end else begin
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (expected_reads.size() == 0) begin
                report_mismatch("result with nothing pending", o_read_value, '0);
            end else begin
                want = expected_reads.pop_front();
                if (o_hit !== want.hit)
                    report_mismatch("hit", {{(lkvc_pkg::VAL_W-1){1'b0}}, o_hit},
                                    {{(lkvc_pkg::VAL_W-1){1'b0}}, want.hit});
                if (o_read_value !== want.value)
                    report_mismatch("read_value", o_read_value, want.value);
            end
        end
    end

    initial begin
        capacity_reg = lkvc_pkg::CAP_RESET;
        wipe_store();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_access();
        test_capacity_edges();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        if (error_count == 0 && expected_reads.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/lkvc_pkg.sv
src/lkvc_cell.sv
src/lru_key_value_cache.sv
src/lkvc_checker.sv
test/lru_key_value_cache_tb.sv
